// ===== design/positional_list_engine_unit_defines.svh =====
// assertion macros shared by the list engine
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ple_pkg.sv =====
package ple_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned PosW = 7;
  localparam int unsigned ValW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_NEW   = 2'd3
  } cell_sel_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    cell_sel_e sel;
    logic      tok_load;
    logic      tok_run;
  } cell_ctrl_t;

endpackage

// ===== design/positional_list_engine_unit.sv =====
// latency: insert, delete, rejected and unused commands give their result the cycle after start
// search: the token probes from position 1 to the first match or the last entry, one cell
//   probed per cycle; busy is high meanwhile; an empty list answers at once, like an insert
// throughput: one insert or delete per cycle while idle; a search holds the engine until done
// reset: count, token chain and state clear at once; list contents undefined until written
// results are shown for one cycle on done_o; the receiver cannot stall
`include "positional_list_engine_unit_defines.svh"

module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [ple_pkg::CmdW-1:0]      command_i,
  input  logic [ple_pkg::PosW-1:0]      position_i,
  input  logic signed [ple_pkg::ValW-1:0] value_i,
  // result side
  output logic                          done_o,
  output logic                          ok_o,
  output logic [ple_pkg::PosW-1:0]      found_position_o,
  output logic [ple_pkg::PosW-1:0]      count_o,
  output logic                          empty_res_o,
  output logic                          full_res_o
);

  // count must hold CAPACITY itself
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // compare width covering both the position field and the count, plus one
  localparam int unsigned CmpW = ((CntW > ple_pkg::PosW) ? CntW : ple_pkg::PosW) + 1;

  ple_pkg::state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [ple_pkg::ValW-1:0] key_q, key_d;

  logic                     done_q, done_d;
  logic                     ok_q, ok_d;
  logic [ple_pkg::PosW-1:0] found_q, found_d;

  logic accept;
  logic is_insert, is_delete, is_search;
  logic ins_ok, del_ok;
  logic search_go;
  logic any_hit, scan_last;
  logic tok_run;

  logic [CmpW-1:0] pos_ext, cnt_ext;

  logic [ple_pkg::ValW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_probe;
  logic [CAPACITY-1:0]      cell_hit;
  ple_pkg::cell_ctrl_t      cell_ctrl [CAPACITY];

  // ---------------------------------------------------------------------------
  // command decode and bounds checks
  // ---------------------------------------------------------------------------
  assign accept  = start && !busy;
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);

  always_comb begin
    is_insert = 1'b0;
    is_delete = 1'b0;
    is_search = 1'b0;
    unique case (ple_pkg::cmd_e'(command_i))
      ple_pkg::CMD_INSERT: is_insert = 1'b1;
      ple_pkg::CMD_DELETE: is_delete = 1'b1;
      ple_pkg::CMD_SEARCH: is_search = 1'b1;
      default: ;  // unused code: no operation
    endcase
  end

  // insert may append at count+1, never past a full list
  assign ins_ok = accept && is_insert && (count_q < CntW'(CAPACITY)) &&
                  (pos_ext != '0) && (pos_ext <= cnt_ext + CmpW'(1));
  assign del_ok = accept && is_delete && (pos_ext != '0) && (pos_ext <= cnt_ext);

  // an empty list answers a search at once
  assign search_go = accept && is_search && (count_q != '0);

  // ---------------------------------------------------------------------------
  // search walk: token sits in cell scan_q
  // ---------------------------------------------------------------------------
  assign any_hit   = |cell_hit;
  assign scan_last = ((CmpW'(scan_q) + CmpW'(1)) == cnt_ext);

  // ---------------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::ST_IDLE: begin
        if (search_go) begin
          state_d = ple_pkg::ST_SEARCH;
        end
      end
      ple_pkg::ST_SEARCH: begin
        if (any_hit || scan_last) begin
          state_d = ple_pkg::ST_IDLE;
        end
      end
      default: state_d = ple_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    tok_run = 1'b0;
    unique case (state_q)
      ple_pkg::ST_IDLE: ;
      ple_pkg::ST_SEARCH: begin
        busy    = 1'b1;
        tok_run = !(any_hit || scan_last);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // count, key, scan position and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    count_d = count_q;
    key_d   = key_q;
    scan_d  = scan_q;
    done_d  = 1'b0;
    ok_d    = 1'b0;
    found_d = '0;

    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
    end

    if (state_q == ple_pkg::ST_SEARCH) begin
      if (any_hit) begin
        done_d  = 1'b1;
        ok_d    = 1'b1;
        found_d = ple_pkg::PosW'(CmpW'(scan_q) + CmpW'(1));
      end else if (scan_last) begin
        done_d = 1'b1;
      end else begin
        scan_d = scan_q + CntW'(1);
      end
    end else if (accept) begin
      if (search_go) begin
        key_d  = value_i;
        scan_d = '0;
      end else begin
        // insert, delete, rejected, unused code or search on an empty list
        done_d = 1'b1;
        ok_d   = ins_ok || del_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      done_q  <= done_d;
    end
  end

  // payload only, qualified by done_q or the state
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    ok_q    <= ok_d;
    found_q <= found_d;
  end

  // ---------------------------------------------------------------------------
  // row of cells: slot i holds position i+1
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CmpW-1:0]          here;
    logic [ple_pkg::ValW-1:0] left_data, right_data;
    logic                     left_probe;

    assign here = CmpW'(i + 1);

    // insert: slots after the target take the left neighbor, the target takes the value
    // delete: the target and later slots take the right neighbor
    always_comb begin
      cell_ctrl[i].sel      = ple_pkg::SEL_HOLD;
      cell_ctrl[i].tok_load = search_go;
      cell_ctrl[i].tok_run  = tok_run;
      if (ins_ok) begin
        if (pos_ext == here) begin
          cell_ctrl[i].sel = ple_pkg::SEL_NEW;
        end else if (pos_ext < here) begin
          cell_ctrl[i].sel = ple_pkg::SEL_LEFT;
        end
      end else if (del_ok && (pos_ext <= here)) begin
        cell_ctrl[i].sel = ple_pkg::SEL_RIGHT;
      end
    end

    if (i == 0) begin : g_head
      assign left_data  = value_i;
      assign left_probe = 1'b0;
    end else begin : g_mid
      assign left_data  = cell_data[i-1];
      assign left_probe = cell_probe[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    ple_cell #(
      .FirstCell(i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[i]),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .new_value_i (value_i),
      .key_i       (key_q),
      .probe_i     (left_probe),
      .data_o      (cell_data[i]),
      .probe_o     (cell_probe[i]),
      .hit_o       (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------------------
  // result ports
  // ---------------------------------------------------------------------------
  assign done_o           = done_q;
  assign ok_o             = done_q && ok_q;
  assign found_position_o = done_q ? found_q : '0;
  assign count_o          = ple_pkg::PosW'(count_q);
  assign empty_res_o      = (count_q == '0);
  assign full_res_o       = (count_q == CntW'(CAPACITY));

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `PLE_ASSERT_NOW(a_one_token, 1'b1, $onehot0(cell_probe), "more than one search token")
  `PLE_ASSERT_NOW(a_busy_no_done, busy, !done_o, "result shown while search runs")
  `PLE_ASSERT_NOW(a_found_ok, done_o && (found_position_o != '0), ok_o, "found without ok")
  `PLE_ASSERT_NEXT(a_search_busy, search_go, busy && $onehot(cell_probe), "search did not start")

endmodule

// ===== design/ple_cell.sv =====
// one list slot: holds an entry, shifts with its neighbors, probes for the search key
module ple_cell #(
  parameter bit FirstCell = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ple_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ple_pkg::ValW-1:0]      left_data_i,
  input  logic [ple_pkg::ValW-1:0]      right_data_i,
  input  logic [ple_pkg::ValW-1:0]      new_value_i,
  input  logic [ple_pkg::ValW-1:0]      key_i,
  input  logic                          probe_i,
  output logic [ple_pkg::ValW-1:0]      data_o,
  output logic                          probe_o,
  output logic                          hit_o
);

  logic [ple_pkg::ValW-1:0] data_q, data_d;
  logic                     probe_q, probe_d;

  always_comb begin
    unique case (ctrl_i.sel)
      ple_pkg::SEL_LEFT:  data_d = left_data_i;
      ple_pkg::SEL_RIGHT: data_d = right_data_i;
      ple_pkg::SEL_NEW:   data_d = new_value_i;
      default:            data_d = data_q;
    endcase
  end

  // search token walks one cell per cycle
  always_comb begin
    if (ctrl_i.tok_load) begin
      probe_d = FirstCell;
    end else if (ctrl_i.tok_run) begin
      probe_d = probe_i;
    end else begin
      probe_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= 1'b0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign data_o  = data_q;
  assign probe_o = probe_q;
  assign hit_o   = probe_q && (data_q == key_i);

endmodule

// ===== sim/positional_list_engine_unit_test.sv =====
`timescale 1ns / 1ps

module positional_list_engine_unit_test;

  localparam int unsigned Capacity = 64;
  // command code 3 is left unused by the engine: no-op with a status result
  localparam logic [ple_pkg::CmdW-1:0] CmdUnused = 2'd3;
  // search probes one cell per cycle, so a full list takes this long at most
  localparam int unsigned DrainCycles = Capacity + 8;

  // what the engine reports for one command
  typedef struct {
    logic                      ok;
    logic [ple_pkg::PosW-1:0]  found_pos;
    logic [ple_pkg::PosW-1:0]  count;
    logic                      empty;
    logic                      full;
  } outcome_t;

  // clock, reset and driven inputs, all known from time zero
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [ple_pkg::CmdW-1:0]        command_i = '0;
  logic [ple_pkg::PosW-1:0]        position_i = '0;
  logic signed [ple_pkg::ValW-1:0] value_i = '0;
  logic                            done_o;
  logic                            ok_o;
  logic [ple_pkg::PosW-1:0]        found_position_o;
  logic [ple_pkg::PosW-1:0]        count_o;
  logic                            empty_res_o;
  logic                            full_res_o;

  // shadow copy of the list, kept in step with accepted commands
  logic signed [ple_pkg::ValW-1:0] list_vals [Capacity];
  int unsigned                     list_len = 0;

  // outcomes of accepted commands, oldest first
  outcome_t               pending_outcomes [$];

  int                     sender_idle_pct = 0;
  int                     error_count = 0;
  int                     results_checked = 0;
  int                     cmd_seen [4] = '{default: 0};
  int                     ok_seen = 0;
  int                     full_seen = 0;
  int unsigned            longest_list = 0;

  positional_list_engine_unit #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .found_position_o(found_position_o),
    .count_o         (count_o),
    .empty_res_o     (empty_res_o),
    .full_res_o      (full_res_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one line per mismatch, capped so a broken build does not flood the log
  task report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // list behavior: apply one command to the shadow list, return its outcome
  function void predict_list_outcome(input logic [ple_pkg::CmdW-1:0] cmd,
                                     input logic [ple_pkg::PosW-1:0] pos,
                                     input logic signed [ple_pkg::ValW-1:0] val,
                                     output outcome_t res);
    int p;
    int i;
    p = int'(pos);
    res.ok = 1'b0;
    res.found_pos = '0;
    if (cmd == ple_pkg::CMD_INSERT) begin
      // rejected when full, at position 0, or past the append slot
      if (list_len < Capacity && p >= 1 && p <= int'(list_len) + 1) begin
        for (i = int'(list_len); i > p - 1; i--) begin
          list_vals[i] = list_vals[i-1];
        end
        list_vals[p-1] = val;
        list_len++;
        res.ok = 1'b1;
      end
    end else if (cmd == ple_pkg::CMD_DELETE) begin
      if (p >= 1 && p <= int'(list_len)) begin
        for (i = p - 1; i + 1 < int'(list_len); i++) begin
          list_vals[i] = list_vals[i+1];
        end
        list_len--;
        res.ok = 1'b1;
      end
    end else if (cmd == ple_pkg::CMD_SEARCH) begin
      // first match wins, so duplicates report the lowest position
      for (i = 0; i < int'(list_len); i++) begin
        if (res.found_pos == '0 && list_vals[i] == val) begin
          res.found_pos = ple_pkg::PosW'(i + 1);
        end
      end
      res.ok = (res.found_pos != '0);
    end
    res.count = ple_pkg::PosW'(list_len);
    res.empty = (list_len == 0);
    res.full = (list_len == Capacity);
  endfunction

  // value mix: extremes, a small cluster that makes duplicates, and anything
  function automatic logic signed [ple_pkg::ValW-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return {1'b1, {(ple_pkg::ValW-1){1'b0}}};
    end else if (r == 1) begin
      return {1'b0, {(ple_pkg::ValW-1){1'b1}}};
    end else if (r < 6) begin
      return ple_pkg::ValW'(int'($urandom_range(6)) - 3);
    end
    return $urandom;
  endfunction

  // hand one item to the engine and record its outcome once accepted;
  // start stays high on return so back-to-back items need no second write
  task automatic send_command(input logic [ple_pkg::CmdW-1:0] cmd,
                              input logic [ple_pkg::PosW-1:0] pos,
                              input logic signed [ple_pkg::ValW-1:0] val);
    outcome_t want;
    // each cycle idles with the set chance before the item goes out
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    // accepted at the first edge that sees busy low
    while (busy !== 1'b0) @(posedge clk_i);
    predict_list_outcome(cmd, pos, val, want);
    pending_outcomes.push_back(want);
    cmd_seen[cmd]++;
    if (want.ok) ok_seen++;
    if (want.full) full_seen++;
    if (list_len > longest_list) longest_list = list_len;
  endtask

  // every strobe must line up with the oldest outstanding command
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_checked++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (ok_o !== want.ok)
          report_mismatch($sformatf("result %0d ok: got %b want %b",
                                    results_checked, ok_o, want.ok));
        if (found_position_o !== want.found_pos)
          report_mismatch($sformatf("result %0d found_position: got %0d want %0d",
                                    results_checked, found_position_o, want.found_pos));
        if (count_o !== want.count)
          report_mismatch($sformatf("result %0d count: got %0d want %0d",
                                    results_checked, count_o, want.count));
        if (empty_res_o !== want.empty)
          report_mismatch($sformatf("result %0d empty: got %b want %b",
                                    results_checked, empty_res_o, want.empty));
        if (full_res_o !== want.full)
          report_mismatch($sformatf("result %0d full: got %b want %b",
                                    results_checked, full_res_o, want.full));
      end
    end
  end

  // hand-picked corners: empty list, bad positions, append, front and
  // middle moves, duplicate search, the unused code; ends with an empty list
  task automatic test_corner_commands();
    send_command(ple_pkg::CMD_SEARCH, 7'd0, 32'sd5);            // search on empty
    send_command(ple_pkg::CMD_DELETE, 7'd1, 32'sd0);            // delete on empty
    send_command(ple_pkg::CMD_INSERT, 7'd0, 32'sd1);            // position 0
    send_command(ple_pkg::CMD_INSERT, 7'd2, 32'sd1);            // past append slot
    send_command(ple_pkg::CMD_INSERT, 7'd1,
                 {1'b1, {(ple_pkg::ValW-1){1'b0}}});            // most negative
    send_command(ple_pkg::CMD_INSERT, 7'd2,
                 {1'b0, {(ple_pkg::ValW-1){1'b1}}});            // append, most positive
    send_command(ple_pkg::CMD_INSERT, 7'd1, 32'sd0);            // front
    send_command(ple_pkg::CMD_INSERT, 7'd2, -32'sd1);           // middle
    send_command(ple_pkg::CMD_INSERT, 7'd5, -32'sd1);           // append a duplicate
    send_command(ple_pkg::CMD_SEARCH, 7'd127, -32'sd1);         // first of duplicates
    send_command(ple_pkg::CMD_SEARCH, 7'd0, {1'b0, {(ple_pkg::ValW-1){1'b1}}});
    send_command(ple_pkg::CMD_SEARCH, 7'd3, 32'sd12345);        // absent
    send_command(CmdUnused, 7'd127, -32'sd1);
    send_command(ple_pkg::CMD_DELETE, 7'd0, 32'sd0);
    send_command(ple_pkg::CMD_DELETE, 7'd6, 32'sd0);            // one past the end
    send_command(ple_pkg::CMD_DELETE, 7'd127, 32'sd0);
    send_command(ple_pkg::CMD_INSERT, 7'd127, 32'sd9);
    send_command(ple_pkg::CMD_INSERT, 7'd7, 32'sd9);            // count + 2
    send_command(ple_pkg::CMD_DELETE, 7'd3, 32'sd0);            // middle
    send_command(ple_pkg::CMD_DELETE, 7'd4, 32'sd0);            // last
    send_command(ple_pkg::CMD_DELETE, 7'd1, 32'sd0);            // front
    send_command(ple_pkg::CMD_SEARCH, 7'd1, 32'sd0);            // value just removed
    send_command(CmdUnused, 7'd0, 32'sd0);
    send_command(ple_pkg::CMD_DELETE, 7'd1, 32'sd0);
    send_command(ple_pkg::CMD_DELETE, 7'd1, 32'sd0);
  endtask

  // fill to the brim at random positions, poke the full list, then drain
  task automatic test_fill_to_capacity();
    while (list_len < Capacity) begin
      send_command(ple_pkg::CMD_INSERT,
                   ple_pkg::PosW'($urandom_range(list_len + 1, 1)), pick_value());
    end
    send_command(ple_pkg::CMD_INSERT, ple_pkg::PosW'(Capacity + 1), 32'sd3); // append when full
    send_command(ple_pkg::CMD_INSERT, 7'd1, 32'sd3);            // front when full
    send_command(ple_pkg::CMD_SEARCH, 7'd0, list_vals[Capacity-1]); // deepest probe
    send_command(ple_pkg::CMD_SEARCH, 7'd0, $urandom);
    send_command(CmdUnused, 7'd64, 32'sd0);
    while (list_len > 0) begin
      if ($urandom_range(3) == 0) begin
        send_command(ple_pkg::CMD_SEARCH, 7'd0, list_vals[$urandom_range(list_len - 1)]);
      end
      send_command(ple_pkg::CMD_DELETE, ple_pkg::PosW'($urandom_range(list_len, 1)), 32'sd0);
    end
  endtask

  // mostly well-formed commands that swing the list between empty and full,
  // with a thin layer of arbitrary codes and positions on top
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int                              roll;
    bit                              growing;
    logic [ple_pkg::CmdW-1:0]        cmd;
    logic [ple_pkg::PosW-1:0]        pos;
    logic signed [ple_pkg::ValW-1:0] val;
    sender_idle_pct = idle_pct;
    growing = 1'b1;
    repeat (n_items) begin
      if (list_len == Capacity) growing = 1'b0;
      else if (list_len == 0) growing = 1'b1;
      else if ($urandom_range(99) < 2) growing = !growing;
      roll = $urandom_range(99);
      val = pick_value();
      if (roll < 6) begin
        // noise: any code, any position
        cmd = ple_pkg::CmdW'($urandom_range(3));
        pos = ple_pkg::PosW'($urandom_range(127));
        val = $urandom;
      end else if (roll < (growing ? 60 : 25)) begin
        cmd = ple_pkg::CMD_INSERT;
        pos = ple_pkg::PosW'($urandom_range(list_len + 1, 1));
      end else if (roll < 80) begin
        cmd = ple_pkg::CMD_DELETE;
        pos = (list_len == 0) ? 7'd1 : ple_pkg::PosW'($urandom_range(list_len, 1));
      end else begin
        cmd = ple_pkg::CMD_SEARCH;
        pos = ple_pkg::PosW'($urandom_range(127));
        // aim at a stored value more often than not
        if (list_len > 0 && $urandom_range(99) < 60) begin
          val = list_vals[$urandom_range(list_len - 1)];
        end
      end
      send_command(cmd, pos, val);
    end
  endtask

  initial begin : run_tests
    int guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 20;
    test_corner_commands();
    test_fill_to_capacity();
    test_random_traffic(600, 20);
    test_random_traffic(600, 81);
    // no gaps at all: back-to-back commands behind busy
    test_random_traffic(600, 0);
    start <= 1'b0;

    // let outstanding results come back, bounded by the longest search
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 4 * DrainCycles) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
    end

    $display("covered %0d inserts, %0d deletes, %0d searches, %0d unused codes; %0d succeeded",
             cmd_seen[ple_pkg::CMD_INSERT], cmd_seen[ple_pkg::CMD_DELETE],
             cmd_seen[ple_pkg::CMD_SEARCH], cmd_seen[CmdUnused], ok_seen);
    $display("list peaked at %0d entries, full on %0d results, %0d results checked",
             longest_list, full_seen, results_checked);
    if (error_count == 0) begin
      $display("positional_list_engine_unit_test: done, clean");
    end else begin
      $display("positional_list_engine_unit_test: done, errors");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("positional_list_engine_unit_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine_unit.sv
sim/positional_list_engine_unit_test.sv
